// ----- rtl/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 3;
  localparam int POS_W = 16;
  localparam int VAL_W = 32;
  localparam int FI_W  = 5;
  localparam int CT_W  = 5;
  localparam int ST_W  = 2;

  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             shift;
    logic [VAL_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic sel;
    logic above;
    logic live;
    logic rd_sel;
  } cell_pos_t;

endpackage

// ----- rtl/ole_cell.sv -----
// ----------------------------------------------------------------------------
// ole_cell
// One storage cell of the list: shifts with its neighbors, compares the key
// and passes read data and the first-match flag along the chain.
// ----------------------------------------------------------------------------
module ole_cell
  import ole_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  cell_pos_t        pos,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  input  logic             hit_in,
  input  logic [VAL_W-1:0] rd_in,
  output logic [VAL_W-1:0] val_q,
  output logic             hit_out,
  output logic             first,
  output logic [VAL_W-1:0] rd_out
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             match;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      case (ctrl.op)
        CELL_INS: begin
          if (pos.sel) begin
            val_nxt = ctrl.key;
          end else if (pos.above) begin
            val_nxt = left_val;
          end
        end
        CELL_DEL: begin
          if (pos.sel || pos.above) begin
            val_nxt = right_val;
          end
        end
        default: val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign match   = pos.live && (val_r == ctrl.key);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;
  assign rd_out  = rd_in | (pos.rd_sel ? val_r : '0);
  assign val_q   = val_r;

endmodule

// ----- rtl/ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed values kept in a row of shifting cells,
// with push, pop, insert, erase, read and find commands.
// ----------------------------------------------------------------------------
// result: registered; it shows on out_valid in the cycle after the transaction is accepted
// throughput: one transaction per cycle while out_ready does not hold back a pending result
// reset: entry count and output valid clear; cell contents stay undefined
// ----------------------------------------------------------------------------
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic signed [POS_W-1:0] in_position,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic signed [FI_W-1:0]  out_found_index,
  output logic [CT_W-1:0]  out_entry_count,
  output logic [ST_W-1:0]  out_status
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [VAL_W-1:0] rd_r;
  logic [FI_W-1:0]  fi_r;
  logic [CT_W-1:0]  ct_r;
  logic [ST_W-1:0]  st_r;

  logic             accept;
  logic             is_push, is_pop, is_ins, is_del, is_read, is_find;
  logic             full, empty;
  logic             pos_le0, pos_neg;
  logic [POS_W-1:0] cnt_ext;
  logic [POS_W-1:0] cnt_m1_ext;
  logic             pos_ge_cnt, pos_ge_last;
  logic [IDX_W-1:0] tgt;
  logic             rd_ok;
  cell_ctrl_t       ctrl;
  status_t          st_nxt;
  logic [VAL_W-1:0] rd_nxt;
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W+FI_W-1:0] fi_ext;
  logic [CNT_W+CT_W-1:0] ct_ext;

  logic [VAL_W-1:0] val_w [DEPTH];
  logic [DEPTH:0]   hit_w;
  logic [VAL_W-1:0] rd_w  [DEPTH+1];
  logic [DEPTH-1:0] first_w;
  cell_pos_t        pos_w [DEPTH];

  assign accept  = in_valid && in_ready;
  assign in_ready = rst_n && (!out_valid_r || out_ready);

  assign is_push = (in_cmd == CMD_PUSH);
  assign is_pop  = (in_cmd == CMD_POP);
  assign is_ins  = is_push || (in_cmd == CMD_INSERT);
  assign is_del  = is_pop || (in_cmd == CMD_ERASE);
  assign is_read = (in_cmd == CMD_READ);
  assign is_find = (in_cmd == CMD_FIND);

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_neg = in_position[POS_W-1];
  assign pos_le0 = pos_neg || (in_position == '0);

  assign cnt_ext     = POS_W'(count_r);
  assign cnt_m1_ext  = POS_W'(count_r - CNT_W'(1));
  assign pos_ge_cnt  = !pos_neg && (in_position >= cnt_ext);
  assign pos_ge_last = !pos_neg && (in_position >= cnt_m1_ext);
  assign rd_ok       = !pos_neg && !pos_ge_cnt;

  // target slot for insert and erase, after clamping
  always_comb begin
    tgt = in_position[IDX_W-1:0];
    if (is_ins) begin
      if (is_push || empty || pos_le0) begin
        tgt = '0;
      end else if (pos_ge_cnt) begin
        tgt = count_r[IDX_W-1:0];
      end
    end else begin
      if (is_pop || pos_le0 || (count_r <= CNT_W'(1))) begin
        tgt = '0;
      end else if (pos_ge_last) begin
        tgt = IDX_W'(count_r - CNT_W'(1));
      end
    end
  end

  always_comb begin
    ctrl.key   = in_item_value;
    ctrl.op    = CELL_HOLD;
    ctrl.shift = 1'b0;
    st_nxt     = ST_DONE;
    count_nxt  = count_r;
    if (is_ins) begin
      if (full) begin
        st_nxt = ST_FULL;
      end else begin
        ctrl.op    = CELL_INS;
        ctrl.shift = accept;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else if (is_del) begin
      if (empty) begin
        st_nxt = ST_EMPTY;
      end else begin
        ctrl.op    = CELL_DEL;
        ctrl.shift = accept;
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VAL_W-1:0] left_v;
      logic [VAL_W-1:0] right_v;

      assign pos_w[gi].sel    = (tgt == IDX_W'(gi));
      assign pos_w[gi].above  = (IDX_W'(gi) > tgt);
      assign pos_w[gi].live   = (CNT_W'(gi) < count_r);
      assign pos_w[gi].rd_sel = rd_ok && (in_position[IDX_W-1:0] == IDX_W'(gi));

      if (gi == 0) begin : g_left_end
        assign left_v = in_item_value;
      end else begin : g_left
        assign left_v = val_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_right_end
        assign right_v = val_w[gi];
      end else begin : g_right
        assign right_v = val_w[gi+1];
      end

      ole_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .pos       (pos_w[gi]),
        .left_val  (left_v),
        .right_val (right_v),
        .hit_in    (hit_w[gi]),
        .rd_in     (rd_w[gi]),
        .val_q     (val_w[gi]),
        .hit_out   (hit_w[gi+1]),
        .first     (first_w[gi]),
        .rd_out    (rd_w[gi+1])
      );
    end
  endgenerate

  assign hit_w[0] = 1'b0;
  assign rd_w[0]  = '0;

  // one-hot first match to index
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_idx = first_idx | (first_w[i] ? IDX_W'(i) : '0);
    end
  end

  assign fi_ext = {{FI_W{1'b0}}, first_idx};
  assign ct_ext = {{CT_W{1'b0}}, count_nxt};
  assign rd_nxt = rd_ok ? rd_w[DEPTH] : VAL_MIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= is_read ? rd_nxt : '0;
      fi_r <= is_find ? (hit_w[DEPTH] ? fi_ext[FI_W-1:0] : {FI_W{1'b1}}) : '0;
      ct_r <= ct_ext[CT_W-1:0];
      st_r <= st_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_r;
  assign out_found_index = fi_r;
  assign out_entry_count = ct_r;
  assign out_status      = st_r;

endmodule

// ----- rtl/ole_checker.sv -----
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks on the ordered list engine result channel.
// ----------------------------------------------------------------------------
module ole_checker
  import ole_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_read_value,
  input logic [FI_W-1:0]  out_found_index,
  input logic [CT_W-1:0]  out_entry_count,
  input logic [ST_W-1:0]  out_status
);

  // held result keeps valid, read value, entry count and status until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_entry_count) && $stable(out_status))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entry_count == CT_W'(DEPTH))
    else $error("dropped insert without a full list");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_entry_count == '0)
    else $error("empty no-op with entries present");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_found_index != '0) && (out_found_index != {FI_W{1'b1}})
      |-> out_found_index < out_entry_count)
    else $error("found index beyond entry count");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_value  (out_read_value),
  .out_found_index (out_found_index),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Exercises the ordered list engine with directed corner commands and then
// random phases that grow, drain and churn the list. A shadow copy of the
// list predicts every result, and each returned transaction is checked field
// by field against the oldest prediction while both handshakes idle at random, save in a calm stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import ole_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] item_value;
  } list_cmd_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic signed [FI_W-1:0]  found_index;
    logic [CT_W-1:0]         entry_count;
    logic [ST_W-1:0]         status;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic signed [POS_W-1:0] in_position = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_read_value;
  logic signed [FI_W-1:0]  out_found_index;
  logic [CT_W-1:0]         out_entry_count;
  logic [ST_W-1:0]         out_status;

  list_cmd_t               pending_cmds[$];
  list_result_t            expected_results[$];
  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  logic [VAL_W-1:0]        value_pool [8];
  int                      shadow_len = 0;
  int                      planned_len = 0;
  int                      n_items = 0;
  int                      accepted = 0;
  int                      errors = 0;
  int                      quiet_cycles = 0;
  logic                    calm;

  assign calm = (accepted >= 300) && (accepted < 420);

  ordered_list_engine uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                           input logic [VAL_W-1:0] val);
    list_cmd_t c;
    c.cmd = cmd;
    c.position = pos[POS_W-1:0];
    c.item_value = val;
    pending_cmds.push_back(c);
    n_items++;
    if ((cmd == CMD_PUSH || cmd == CMD_INSERT) && planned_len < DEPTH) planned_len++;
    else if ((cmd == CMD_POP || cmd == CMD_ERASE) && planned_len > 0) planned_len--;
  endtask

  function automatic list_result_t apply_list_cmd(list_cmd_t c);
    list_result_t r;
    int p;
    int at;
    int i;
    r = '{read_value: '0, found_index: '0, entry_count: '0, status: ST_DONE};
    p = $signed(c.position);
    at = 0;
    case (c.cmd)
      CMD_PUSH, CMD_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.cmd == CMD_PUSH || shadow_len == 0 || p <= 0) at = 0;
          else if (p >= shadow_len) at = shadow_len;
          else at = p;
          for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = c.item_value;
          shadow_len++;
        end
      end
      CMD_POP, CMD_ERASE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.cmd == CMD_POP || p <= 0 || shadow_len <= 1) at = 0;
          else if (p >= shadow_len - 1) at = shadow_len - 1;
          else at = p;
          for (i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      CMD_READ: begin
        r.read_value = (p < 0 || p >= shadow_len) ? VAL_MIN : shadow_list[p];
      end
      CMD_FIND: begin
        r.found_index = '1;
        for (i = shadow_len - 1; i >= 0; i--) begin
          if (shadow_list[i] == c.item_value) r.found_index = i[FI_W-1:0];
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_len[CT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [VAL_W:0] expv,
                             input logic signed [VAL_W:0] actv);
    if (expv !== actv) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
    end
  endtask

  // stimulus and end of run
  initial begin
    int n;
    int bias;
    int roll;
    int pos;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;

    for (n = 0; n < 8; n++) value_pool[n] = $urandom;
    value_pool[0] = VAL_MIN;
    value_pool[1] = '1;
    value_pool[2] = '0;

    // empty list corners
    queue_cmd(CMD_POP, 0, 32'h0);
    queue_cmd(CMD_ERASE, 0, 32'h0);
    queue_cmd(CMD_READ, 0, 32'h0);
    queue_cmd(CMD_FIND, 0, 32'h0);
    // inserts: on empty, front, clamped head, clamped tail, middle
    queue_cmd(CMD_INSERT, 5, 32'h7FFF_FFFF);
    queue_cmd(CMD_PUSH, 0, VAL_MIN);
    queue_cmd(CMD_INSERT, -32768, 32'h1);
    queue_cmd(CMD_INSERT, 32767, 32'hFFFF_FFFF);
    queue_cmd(CMD_INSERT, 2, 32'h1234_5678);
    // reads in and out of range, then finds and the spare commands
    queue_cmd(CMD_READ, -1, 32'h0);
    queue_cmd(CMD_READ, 32767, 32'h0);
    queue_cmd(CMD_READ, 0, 32'h0);
    queue_cmd(CMD_READ, 4, 32'h0);
    queue_cmd(CMD_READ, 5, 32'h0);
    queue_cmd(CMD_FIND, 0, 32'hFFFF_FFFF);
    queue_cmd(CMD_FIND, 0, 32'h0);
    queue_cmd(CMD_SPARE6, 1, 32'h5A5A_5A5A);
    queue_cmd(CMD_SPARE7, -1, 32'hFFFF_FFFF);
    // erases: clamped tail, clamped head, middle, clamped tail, single entry
    queue_cmd(CMD_ERASE, 32767, 32'h0);
    queue_cmd(CMD_ERASE, -32768, 32'h0);
    queue_cmd(CMD_ERASE, 1, 32'h0);
    queue_cmd(CMD_ERASE, 5, 32'h0);
    queue_cmd(CMD_ERASE, 7, 32'h0);

    bias = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) bias = $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < 2) begin
        cmd = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
      end else begin
        roll = $urandom_range(99);
        case (bias)
          0:       cmd = (roll < 70) ? CMD_INSERT : (roll < 80) ? CMD_ERASE : CMD_READ;
          1:       cmd = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_ERASE : CMD_READ;
          default: cmd = (roll < 30) ? CMD_INSERT : (roll < 60) ? CMD_ERASE : CMD_READ;
        endcase
        if ($urandom_range(99) < 30) begin
          if (cmd == CMD_INSERT) cmd = CMD_PUSH;
          else if (cmd == CMD_ERASE) cmd = CMD_POP;
          else cmd = CMD_FIND;
        end
        if (cmd == CMD_READ && $urandom_range(1)) cmd = CMD_FIND;
      end
      if ($urandom_range(99) < 80) pos = $urandom_range(planned_len + 2) - 2;
      else pos = $urandom;
      if ($urandom_range(1)) val = value_pool[$urandom_range(7)];
      else val = $urandom;
      queue_cmd(cmd, pos, val);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < n_items || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    list_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.cmd = in_cmd;
        c.position = in_position;
        c.item_value = in_item_value;
        expected_results.push_back(apply_list_cmd(c));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_cmd <= c.cmd;
          in_position <= c.position;
          in_item_value <= c.item_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 33);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual count %0d",
                   $time, out_entry_count);
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", want.read_value, out_read_value);
          check_field("found_index", want.found_index, out_found_index);
          check_field("entry_count", want.entry_count, out_entry_count);
          check_field("status", want.status, out_status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
